// ===== design/ipg_pkg.sv =====
// ----------------------------------------------------------------------------
// ipg_pkg
// Shared widths, payload structs and controller/datapath handshake types for
// the im2col patch gather block.
// ----------------------------------------------------------------------------
`default_nettype none

package ipg_pkg;

  // Image geometry; the store is addressed as {channel, y, x}
  localparam int X_W      = 6;
  localparam int Y_W      = 6;
  localparam int CH_W     = 4;
  localparam int SAMPLE_W = 16;
  localparam int ADDR_W   = CH_W + Y_W + X_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // Configuration register widths and limits
  localparam int DIM_W    = 7;
  localparam int CNT_W    = 5;
  localparam int K_W      = 3;
  localparam int S_W      = 4;
  localparam int MAX_DIM  = 64;
  localparam int MAX_CH   = 16;

  // Derived widths
  localparam int KK_W     = 2 * K_W;
  localparam int PROD_W   = X_W + S_W;
  localparam int COORD_W  = PROD_W + 1;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 12;

  // Output-grid divider: one quotient bit per step
  localparam int DIV_STEPS = X_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_KERNEL_SIZE   = 3'd3,
    CFG_STRIDE_STEP   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_GATHER = 1'b1
  } op_t;

  typedef struct packed {
    logic                       operation;
    logic [X_W-1:0]             pixel_x;
    logic [Y_W-1:0]             pixel_y;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] pixel_value;
    logic [X_W-1:0]             out_x;
    logic [Y_W-1:0]             out_y;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] tap_value;
    logic [ROW_W-1:0]           row_index;
    logic [COL_W-1:0]           column_index;
    logic                       padded;
    logic                       last_tap;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic div_start;  // load the output-grid divider
    logic div_step;   // one divider step
    logic setup;      // compute patch anchor, column and row base
    logic issue;      // launch one tap read
  } ipg_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic op_gather;  // operation of the item offered on the input
    logic div_last;   // divider step in progress is the final one
    logic gather_ok;  // latched gather lies on the output grid and in a valid channel
    logic issue_ok;   // tap pipeline can take a tap
    logic tap_last;   // current tap counter is the final tap
  } ipg_stat_t;

endpackage

`default_nettype wire

// ===== design/ipg_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipg_ctrl
// Sequencer: recomputes the output grid after reset and configuration writes,
// takes input items, and steps the datapath through setup and tap issue.
// ----------------------------------------------------------------------------
`default_nettype none

module ipg_ctrl
  import ipg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      cfg_wr,
  input  wire ipg_stat_t stat,
  output ipg_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SETUP,
    ST_TAP
  } state_t;

  state_t state_r, state_nxt;
  logic   dirty_r, dirty_nxt;

  assign in_ready = (state_r == ST_IDLE) && !dirty_r;

  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (dirty_r) begin
          cmd.div_start = 1'b1;
          dirty_nxt     = 1'b0;
          state_nxt     = ST_CALC;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.op_gather) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_CALC: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.gather_ok ? ST_TAP : ST_IDLE;
      end
      ST_TAP: begin
        cmd.issue = stat.issue_ok;
        if (stat.issue_ok && stat.tap_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // a write always forces a fresh grid computation
    if (cfg_wr) begin
      dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dirty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  a_cfg_marks_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> dirty_r)
    else $error("configuration write did not schedule a grid update");

  a_no_accept_while_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    dirty_r |-> !cmd.accept)
    else $error("item taken before output grid was updated");

  a_issue_only_in_tap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (state_r == ST_TAP) && stat.issue_ok)
    else $error("tap issued outside the tap phase or into a full pipeline");

endmodule

`default_nettype wire

// ===== design/ipg_datapath.sv =====
// ----------------------------------------------------------------------------
// ipg_datapath
// Configuration registers, output-grid divider, image store, tap address
// counters and the two-stage read/output pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ipg_datapath
  import ipg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire ipg_cmd_t              cmd,
  output ipg_stat_t                  stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  // ---------------- configuration ----------------
  logic [DIM_W-1:0] width_r, height_r;
  logic [CNT_W-1:0] chans_r;
  logic [K_W-1:0]   ksize_r;
  logic [S_W-1:0]   stride_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_DIM);
      height_r <= DIM_W'(MAX_DIM);
      chans_r  <= CNT_W'(1);
      ksize_r  <= K_W'(3);
      stride_r <= S_W'(1);
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r <= cfg_data[DIM_W-1:0];
        CFG_CHANNEL_COUNT: chans_r  <= cfg_data[CNT_W-1:0];
        CFG_KERNEL_SIZE:   ksize_r  <= cfg_data[K_W-1:0];
        CFG_STRIDE_STEP:   stride_r <= cfg_data[S_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate registers into their legal range
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0] nc_eff;
  logic [K_W-1:0]   k_eff;
  logic [S_W-1:0]   s_eff;
  logic [K_W-1:0]   half;

  always_comb begin
    w_eff  = (width_r == '0) ? DIM_W'(1) :
             (width_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_r;
    h_eff  = (height_r == '0) ? DIM_W'(1) :
             (height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_r;
    nc_eff = (chans_r == '0) ? CNT_W'(1) :
             (chans_r > CNT_W'(MAX_CH)) ? CNT_W'(MAX_CH) : chans_r;
    k_eff  = (ksize_r == '0) ? K_W'(1) : ksize_r;
    s_eff  = (stride_r == '0) ? S_W'(1) : stride_r;
    half   = (k_eff - K_W'(1)) >> 1;
  end

  // ---------------- output grid divider ----------------
  // outw = (w-1)/s + 1, outh likewise; restoring division, one bit per step
  logic [X_W-1:0]       qw_r, qh_r;
  logic [S_W-1:0]       remw_r, remh_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [KK_W-1:0]      kk_r;
  logic [S_W:0]         trial_w, trial_h;
  logic [DIM_W-1:0]     outw, outh;

  assign trial_w = {remw_r, qw_r[X_W-1]};
  assign trial_h = {remh_r, qh_r[X_W-1]};
  assign outw    = {1'b0, qw_r} + DIM_W'(1);
  assign outh    = {1'b0, qh_r} + DIM_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      qw_r      <= X_W'(w_eff - DIM_W'(1));
      qh_r      <= Y_W'(h_eff - DIM_W'(1));
      remw_r    <= '0;
      remh_r    <= '0;
      div_cnt_r <= '0;
      kk_r      <= KK_W'(k_eff) * KK_W'(k_eff);
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      if (trial_w >= {1'b0, s_eff}) begin
        remw_r <= S_W'(trial_w - {1'b0, s_eff});
        qw_r   <= {qw_r[X_W-2:0], 1'b1};
      end else begin
        remw_r <= trial_w[S_W-1:0];
        qw_r   <= {qw_r[X_W-2:0], 1'b0};
      end
      if (trial_h >= {1'b0, s_eff}) begin
        remh_r <= S_W'(trial_h - {1'b0, s_eff});
        qh_r   <= {qh_r[X_W-2:0], 1'b1};
      end else begin
        remh_r <= trial_h[S_W-1:0];
        qh_r   <= {qh_r[X_W-2:0], 1'b0};
      end
    end
  end

  // ---------------- image store ----------------
  logic [SAMPLE_W-1:0] store [STORE_DEPTH];
  logic [SAMPLE_W-1:0] rd_q;
  logic                wr_ok;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;

  assign wr_ok = ({1'b0, in_data.pixel_x} < w_eff) &&
                 ({1'b0, in_data.pixel_y} < h_eff) &&
                 ({1'b0, in_data.channel} < nc_eff);
  assign wr_addr = {in_data.channel, in_data.pixel_y, in_data.pixel_x};

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.operation == OP_WRITE) && wr_ok) begin
      store[wr_addr] <= in_data.pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_q <= store[rd_addr];
    end
  end

  // ---------------- gather request and tap counters ----------------
  logic [CH_W-1:0]           g_ch_r;
  logic [X_W-1:0]            g_ox_r;
  logic [Y_W-1:0]            g_oy_r;
  logic signed [COORD_W-1:0] ax_r, xc_r, yc_r;
  logic [K_W-1:0]            kx_r, ky_r;
  logic [ROW_W-1:0]          row_r;
  logic [COL_W-1:0]          col_r;
  logic                      tap_pad;
  logic                      kx_end;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      g_ch_r <= in_data.channel;
      g_ox_r <= in_data.out_x;
      g_oy_r <= in_data.out_y;
    end
  end

  assign kx_end  = (kx_r == k_eff - K_W'(1));
  assign tap_pad = xc_r[COORD_W-1] || yc_r[COORD_W-1] ||
                   (xc_r >= $signed(COORD_W'(w_eff))) ||
                   (yc_r >= $signed(COORD_W'(h_eff)));
  assign rd_addr = {g_ch_r, yc_r[Y_W-1:0], xc_r[X_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ax_r  <= $signed(COORD_W'(PROD_W'(g_ox_r) * PROD_W'(s_eff))) -
               $signed(COORD_W'(half));
      xc_r  <= $signed(COORD_W'(PROD_W'(g_ox_r) * PROD_W'(s_eff))) -
               $signed(COORD_W'(half));
      yc_r  <= $signed(COORD_W'(PROD_W'(g_oy_r) * PROD_W'(s_eff))) -
               $signed(COORD_W'(half));
      kx_r  <= '0;
      ky_r  <= '0;
      row_r <= ROW_W'(g_ch_r) * ROW_W'(kk_r);
      col_r <= COL_W'(g_oy_r) * COL_W'(outw) + COL_W'(g_ox_r);
    end else if (cmd.issue) begin
      row_r <= row_r + ROW_W'(1);
      if (kx_end) begin
        kx_r <= '0;
        xc_r <= ax_r;
        ky_r <= ky_r + K_W'(1);
        yc_r <= yc_r + COORD_W'(1);
      end else begin
        kx_r <= kx_r + K_W'(1);
        xc_r <= xc_r + COORD_W'(1);
      end
    end
  end

  // ---------------- read stage and output register ----------------
  logic             s1_valid_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_pad_r, s1_last_r;
  logic             s1_adv;
  logic             out_valid_r;
  out_item_t        out_data_r;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_pad_r  <= tap_pad;
      s1_last_r <= kx_end && (ky_r == k_eff - K_W'(1));
    end
    if (s1_adv) begin
      out_data_r.tap_value    <= s1_pad_r ? '0 : $signed(rd_q);
      out_data_r.row_index    <= s1_row_r;
      out_data_r.column_index <= s1_col_r;
      out_data_r.padded       <= s1_pad_r;
      out_data_r.last_tap     <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.issue) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.op_gather = (in_data.operation == OP_GATHER);
    stat.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    stat.gather_ok = ({1'b0, g_ox_r} < outw) && ({1'b0, g_oy_r} < outh) &&
                     ({1'b0, g_ch_r} < nc_eff);
    stat.issue_ok  = !s1_valid_r || s1_adv;
    stat.tap_last  = kx_end && (ky_r == k_eff - K_W'(1));
  end

  a_no_stage_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !cmd.issue)
    else $error("tap read overwrote a stalled read stage");

  a_pad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.padded) |-> (out_data_r.tap_value == '0))
    else $error("padded tap carries a nonzero sample");

  a_issue_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && !tap_pad) |-> (!xc_r[COORD_W-1] && !yc_r[COORD_W-1]))
    else $error("unpadded tap addresses a negative coordinate");

endmodule

`default_nettype wire

// ===== design/im2col_patch_gather.sv =====
// ----------------------------------------------------------------------------
// im2col_patch_gather
// im2col with same-size padding over a stored multi-channel Q8.8 image.
//
// Input channel (in_valid/in_ready/in_data): a write item stores one pixel at
// (pixel_x, pixel_y, channel); out-of-range writes are dropped.
// A gather item emits kernel_size^2 taps in kernel row-major order on the
// output channel (out_valid/out_ready/out_data), last_tap marking the final
// one; gathers off the output grid or past the channel count emit nothing.
// Gather sequence: a setup step after the transfer, then one tap read per
// cycle from the single image memory read port while the tap pipeline can
// take a tap. Each tap passes the read stage and the output register.
// Receiver stall: the read stage and output register hold; tap reads pause
// and resume without loss. The next item is taken while earlier taps drain.
// Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready. After reset and after every register write, the output grid size is
// recomputed by the divider with in_ready low. The image store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_patch_gather
  import ipg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ipg_cmd_t  cmd;
  ipg_stat_t stat;
  logic      cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  ipg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_wr   (cfg_wr),
    .stat     (stat),
    .cmd      (cmd)
  );

  ipg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for im2col_patch_gather. A local copy of the image and
// of the register file predicts every tap of each gathered patch. Taps are
// checked in order against the output channel under several register
// settings and sender/receiver idle profiles.
// ----------------------------------------------------------------------------
module tb;
  import ipg_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 24;
  localparam int HEAVY_PCT     = 82;
  localparam int LIGHT_PCT     = 27;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  typedef enum {PROFILE_NONE, PROFILE_SENDER, PROFILE_RECEIVER, PROFILE_BOTH} idle_profile_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Local image copy and register file
  logic signed [SAMPLE_W-1:0] image_copy [STORE_DEPTH];
  bit                         pixel_known [STORE_DEPTH];
  logic [DIM_W-1:0]           width_reg  = 7'd64;
  logic [DIM_W-1:0]           height_reg = 7'd64;
  logic [CNT_W-1:0]           chan_reg   = 5'd1;
  logic [K_W-1:0]             kernel_reg = 3'd3;
  logic [S_W-1:0]             stride_reg = 4'd1;
  int img_w, img_h, chans, ksize, stride, grid_w, grid_h;

  out_item_t expected_taps [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int taps_checked   = 0;
  int gathers_done   = 0;
  int items_done     = 0;
  int settings_done  = 0;

  im2col_patch_gather dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int clamp_dim(input int v, input int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic void refresh_geometry();
    img_w  = clamp_dim(width_reg, MAX_DIM);
    img_h  = clamp_dim(height_reg, MAX_DIM);
    chans  = clamp_dim(chan_reg, MAX_CH);
    ksize  = (kernel_reg == 0) ? 1 : kernel_reg;
    stride = (stride_reg == 0) ? 1 : stride_reg;
    grid_w = (img_w - 1) / stride + 1;
    grid_h = (img_h - 1) / stride + 1;
  endfunction

  function automatic int store_index(input int c, input int y, input int x);
    return (c * MAX_DIM + y) * MAX_DIM + x;
  endfunction

  function automatic bit tap_inside(input int x, input int y);
    return x >= 0 && y >= 0 && x < img_w && y < img_h;
  endfunction

  // Update the image copy, or queue the taps one accepted gather must produce
  function automatic void predict_transfer(input in_item_t item);
    int        ox, oy, c, half, xc, yc;
    out_item_t tap;
    c = item.channel;
    if (item.operation == OP_WRITE) begin
      if (tap_inside(item.pixel_x, item.pixel_y) && c < chans) begin
        image_copy[store_index(c, item.pixel_y, item.pixel_x)] = item.pixel_value;
        pixel_known[store_index(c, item.pixel_y, item.pixel_x)] = 1'b1;
        items_done++;
      end
    end else begin
      ox = item.out_x;
      oy = item.out_y;
      if (ox < grid_w && oy < grid_h && c < chans) begin
        half = (ksize - 1) / 2;
        for (int ky = 0; ky < ksize; ky++) begin
          for (int kx = 0; kx < ksize; kx++) begin
            xc = ox * stride - half + kx;
            yc = oy * stride - half + ky;
            tap.padded = !tap_inside(xc, yc);
            if (tap.padded) begin
              tap.tap_value = '0;
            end else begin
              tap.tap_value = image_copy[store_index(c, yc, xc)];
            end
            tap.row_index    = ROW_W'(c * ksize * ksize + ky * ksize + kx);
            tap.column_index = COL_W'(oy * grid_w + ox);
            tap.last_tap     = (ky == ksize - 1) && (kx == ksize - 1);
            expected_taps.push_back(tap);
          end
        end
        items_done++;
        gathers_done++;
      end
    end
  endfunction

  function automatic void set_profile(input idle_profile_t profile);
    case (profile)
      PROFILE_SENDER: begin
        send_idle_pct  = HEAVY_PCT;
        recv_stall_pct = 0;
      end
      PROFILE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = HEAVY_PCT;
      end
      PROFILE_BOTH: begin
        send_idle_pct  = LIGHT_PCT;
        recv_stall_pct = LIGHT_PCT;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic int hot_coord(input int n);
    int v = $urandom_range(3);
    if (v < 2) return (v < n) ? v : n - 1;
    return (n - 4 + v >= 0) ? n - 4 + v : 0;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_transfer(item);
    @(negedge clk);
  endtask

  task automatic write_pixel(input int x, input int y, input int c, input int v);
    in_item_t item;
    item.operation   = OP_WRITE;
    item.pixel_x     = X_W'(x);
    item.pixel_y     = Y_W'(y);
    item.channel     = CH_W'(c);
    item.pixel_value = SAMPLE_W'(v);
    item.out_x       = X_W'($urandom);
    item.out_y       = Y_W'($urandom);
    send_item(item);
  endtask

  // Write every unwritten in-image pixel of the patch first, then gather it
  task automatic gather_patch(input int ox, input int oy, input int c);
    in_item_t item;
    int       half, xc, yc;
    if (ox < grid_w && oy < grid_h && c < chans) begin
      half = (ksize - 1) / 2;
      for (int ky = 0; ky < ksize; ky++) begin
        for (int kx = 0; kx < ksize; kx++) begin
          xc = ox * stride - half + kx;
          yc = oy * stride - half + ky;
          if (tap_inside(xc, yc) && !pixel_known[store_index(c, yc, xc)]) begin
            write_pixel(xc, yc, c, $urandom);
          end
        end
      end
    end
    item.operation   = OP_GATHER;
    item.pixel_x     = X_W'($urandom);
    item.pixel_y     = Y_W'($urandom);
    item.channel     = CH_W'(c);
    item.pixel_value = SAMPLE_W'($urandom);
    item.out_x       = X_W'(ox);
    item.out_y       = Y_W'(oy);
    send_item(item);
  endtask

  // Drop valid and hold until every queued tap has arrived and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_taps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] data = CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:   width_reg  = data[DIM_W-1:0];
      CFG_IMAGE_HEIGHT:  height_reg = data[DIM_W-1:0];
      CFG_CHANNEL_COUNT: chan_reg   = data[CNT_W-1:0];
      CFG_KERNEL_SIZE:   kernel_reg = data[K_W-1:0];
      CFG_STRIDE_STEP:   stride_reg = data[S_W-1:0];
      default: ;
    endcase
    refresh_geometry();
    @(negedge clk);
  endtask

  task automatic apply_setting(input int w, input int h, input int nc, input int k,
                               input int s);
    settle();
    set_reg(CFG_IMAGE_WIDTH, w);
    set_reg(CFG_IMAGE_HEIGHT, h);
    set_reg(CFG_CHANNEL_COUNT, nc);
    set_reg(CFG_KERNEL_SIZE, k);
    set_reg(CFG_STRIDE_STEP, s);
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  task automatic test_reset_state();
    gather_patch(63, 63, 0);
    gather_patch(0, 0, 0);
  endtask

  task automatic test_extreme_samples();
    apply_setting(64, 64, 16, 1, 1);
    write_pixel(0, 0, 0, -32768);
    write_pixel(63, 63, 15, 32767);
    write_pixel(63, 0, 5, 0);
    write_pixel(0, 63, 10, -1);
    gather_patch(0, 0, 0);
    gather_patch(63, 63, 15);
    gather_patch(63, 0, 5);
    gather_patch(0, 63, 10);
  endtask

  task automatic test_out_of_range();
    apply_setting(10, 5, 2, 3, 1);
    write_pixel(10, 0, 0, $urandom);
    write_pixel(0, 5, 1, $urandom);
    write_pixel(1, 1, 2, $urandom);
    gather_patch(10, 0, 0);
    gather_patch(0, 5, 1);
    gather_patch(0, 0, 2);
    // Indexes past the register list must leave the geometry alone
    settle();
    for (int i = int'(CFG_STRIDE_STEP) + 1; i <= int'(CFG_IDX_TOP); i++) begin
      set_reg(CFG_IDX_W'(i), 1);
    end
    cfg_valid <= 1'b0;
    gather_patch(9, 4, 1);
  endtask

  task automatic run_random_phase(input int w, input int h, input int nc, input int k,
                                  input int s, input idle_profile_t profile);
    int target, pick;
    bit paused;
    apply_setting(w, h, nc, k, s);
    set_profile(profile);
    target = items_done + PHASE_ITEMS;
    paused = 1'b0;
    while (items_done < target) begin
      if (!paused && items_done >= target - PHASE_ITEMS / 2) begin
        settle();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        gather_patch(hot_coord(grid_w), hot_coord(grid_h), $urandom_range(chans - 1));
      end else if (pick < 70) begin
        gather_patch($urandom_range(grid_w - 1), $urandom_range(grid_h - 1),
                     $urandom_range(chans - 1));
      end else if (pick < 85) begin
        write_pixel($urandom_range(63), $urandom_range(63), $urandom_range(15), $urandom);
      end else begin
        gather_patch($urandom_range(63), $urandom_range(63), $urandom_range(15));
      end
    end
    set_profile(PROFILE_NONE);
  endtask

  task automatic test_random_settings();
    run_random_phase(64, 64, 16, 7, 1, PROFILE_NONE);
    run_random_phase(1, 1, 1, 1, 1, PROFILE_SENDER);
    run_random_phase(13, 9, 3, 5, 3, PROFILE_RECEIVER);
    run_random_phase(0, 127, 0, 8, 0, PROFILE_BOTH);
    run_random_phase(100, 20, 31, 7, 15, PROFILE_NONE);
    run_random_phase(37, 50, 4, 3, 8, PROFILE_SENDER);
    run_random_phase(64, 64, 16, 3, 2, PROFILE_RECEIVER);
    run_random_phase(6, 64, 9, 6, 9, PROFILE_BOTH);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_taps.size() == 0) begin
        $display("%0t: unexpected tap: value %0d row %0d col %0d pad %b last %b", $time,
                 out_data.tap_value, out_data.row_index, out_data.column_index,
                 out_data.padded, out_data.last_tap);
        errors++;
      end else begin
        want = expected_taps.pop_front();
        taps_checked++;
        if (out_data !== want) begin
          $display("%0t: tap mismatch: expected value %0d row %0d col %0d pad %b last %b",
                   $time, want.tap_value, want.row_index, want.column_index,
                   want.padded, want.last_tap);
          $display("%0t:                 actual value %0d row %0d col %0d pad %b last %b",
                   $time, out_data.tap_value, out_data.row_index, out_data.column_index,
                   out_data.padded, out_data.last_tap);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("[im2col_patch_gather] ERROR");
    $finish;
  end

  initial begin
    refresh_geometry();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_extreme_samples();
    test_out_of_range();
    test_random_settings();
    settle();
    $display("Covered %0d effective transfers, %0d patch gathers, %0d register settings;",
             items_done, gathers_done, settings_done);
    $display("%0d taps compared under free-running, sender-idle, receiver-stall and mixed traffic.",
             taps_checked);
    if (errors == 0) begin
      $display("[im2col_patch_gather] OK");
    end else begin
      $display("[im2col_patch_gather] ERROR");
    end
    $finish;
  end

endmodule
